>>> rtl/core/der_tlv_header_parser_unit_macros.svh
// Assertion macros for the DER TLV header parser.
`ifndef DER_TLV_HEADER_PARSER_UNIT_MACROS_SVH
`define DER_TLV_HEADER_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is low.
`define DTLV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dtlv assertion failed");

// Next-cycle implication, disabled while reset is low.
`define DTLV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dtlv assertion failed");

`else

`define DTLV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DTLV_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/dtlv_pkg.sv
package dtlv_pkg;

  localparam int unsigned COUNT_BITS_DEF       = 32;
  localparam int unsigned MAX_LENGTH_BYTES_DEF = 8;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 144;

  localparam logic [4:0] HIGH_TAG_MARK = 5'h1F;
  localparam logic [3:0] TAG_BYTES_MAX = 4'd10;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_INCOMPLETE = 2'd1,
    ERR_TAG_OVF    = 2'd2,
    ERR_LENGTH     = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    PH_IDENT = 2'd0,
    PH_TAG   = 2'd1,
    PH_LEN   = 2'd2,
    PH_LONG  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] bytes_after;
  } item_t;

  typedef struct packed {
    err_e        error_code;
    logic [62:0] tag_number;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [4:0]  univ_code;
    logic [63:0] content_len;
    logic [4:0]  hdr_len;
  } result_t;

  // Universal class base tag to type code (0 where the tag has no code).
  function automatic logic [4:0] univ_type(input logic [4:0] base);
    logic [4:0] t;
    case (base)
      5'h01:   t = 5'd1;
      5'h02:   t = 5'd2;
      5'h03:   t = 5'd3;
      5'h04:   t = 5'd4;
      5'h05:   t = 5'd5;
      5'h06:   t = 5'd6;
      5'h0C:   t = 5'd7;
      5'h10:   t = 5'd8;
      5'h11:   t = 5'd9;
      5'h13:   t = 5'd10;
      5'h14:   t = 5'd11;
      5'h16:   t = 5'd12;
      5'h17:   t = 5'd13;
      5'h18:   t = 5'd14;
      5'h1C:   t = 5'd15;
      5'h1E:   t = 5'd16;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/core/dtlv_in_stage.sv
module dtlv_in_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [dtlv_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic                                advance_i,
  output logic                                valid_o,
  output dtlv_pkg::item_t                     item_o
);

  logic            valid_q, valid_d;
  dtlv_pkg::item_t item_q;
  logic            accept;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign valid_d         = accept || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_byte   <= s_axis_tdata_i[7:0];
      item_q.bytes_after <= s_axis_tdata_i[39:8];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/core/dtlv_decoder.sv
module dtlv_decoder #(
  parameter int unsigned COUNT_BITS       = dtlv_pkg::COUNT_BITS_DEF,
  parameter int unsigned MAX_LENGTH_BYTES = dtlv_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  dtlv_pkg::item_t     item_i,
  output logic                res_valid_o,
  output dtlv_pkg::result_t   res_o
);

  localparam int unsigned RemW = (COUNT_BITS < 32) ? COUNT_BITS : 32;

  dtlv_pkg::phase_e phase_q, phase_d;
  logic [7:0]  id_q, id_d;
  logic [62:0] tag_acc_q, tag_acc_d;
  logic [3:0]  tag_cnt_q, tag_cnt_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [4:0]  hbc_q, hbc_d;

  logic [7:0]      b;
  logic [RemW-1:0] remain;
  logic [63:0]     remain64;
  logic            remain_zero;
  logic [4:0]      hbc_inc;
  logic [62:0]     tag_acc_next;
  logic [3:0]      tag_cnt_next;
  logic [63:0]     len_acc_next;
  logic [3:0]      len_left_next;
  logic [6:0]      n;
  logic [4:0]      base;
  logic            do_err;
  dtlv_pkg::err_e  err_code;
  logic            do_fin;
  logic [63:0]     fin_len;

  assign b             = item_i.data_byte;
  assign remain        = item_i.bytes_after[RemW-1:0];
  assign remain64      = 64'(remain);
  assign remain_zero   = (remain == '0);
  assign hbc_inc       = hbc_q + 5'd1;
  assign tag_acc_next  = {tag_acc_q[55:0], b[6:0]};
  assign tag_cnt_next  = tag_cnt_q + 4'd1;
  assign len_acc_next  = {len_acc_q[55:0], b};
  assign len_left_next = len_left_q - 4'd1;
  assign n             = b[6:0];
  assign base          = id_q[4:0];

  always_comb begin
    phase_d    = phase_q;
    id_d       = id_q;
    tag_acc_d  = tag_acc_q;
    tag_cnt_d  = tag_cnt_q;
    len_acc_d  = len_acc_q;
    len_left_d = len_left_q;
    hbc_d      = hbc_q;
    do_err     = 1'b0;
    err_code   = dtlv_pkg::ERR_OK;
    do_fin     = 1'b0;
    fin_len    = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (advance_i) begin
      hbc_d = hbc_inc;
      case (phase_q)
        dtlv_pkg::PH_IDENT: begin
          id_d      = b;
          tag_acc_d = '0;
          tag_cnt_d = '0;
          if (remain_zero) begin
            do_err   = 1'b1;
            err_code = dtlv_pkg::ERR_INCOMPLETE;
          end else begin
            phase_d = (b[4:0] == dtlv_pkg::HIGH_TAG_MARK) ? dtlv_pkg::PH_TAG
                                                         : dtlv_pkg::PH_LEN;
          end
        end
        dtlv_pkg::PH_TAG: begin
          tag_acc_d = tag_acc_next;
          tag_cnt_d = tag_cnt_next;
          if (tag_cnt_next >= dtlv_pkg::TAG_BYTES_MAX) begin
            do_err   = 1'b1;
            err_code = dtlv_pkg::ERR_TAG_OVF;
          end else if (remain_zero) begin
            do_err   = 1'b1;
            err_code = dtlv_pkg::ERR_INCOMPLETE;
          end else if (!b[7]) begin
            phase_d = dtlv_pkg::PH_LEN;
          end
        end
        dtlv_pkg::PH_LEN: begin
          if (!b[7]) begin
            do_fin  = 1'b1;
            fin_len = 64'(b);
          end else if (n > 7'(MAX_LENGTH_BYTES)) begin
            do_err   = 1'b1;
            err_code = dtlv_pkg::ERR_LENGTH;
          end else if (n == 7'd0) begin
            do_fin  = 1'b1;
            fin_len = '0;
          end else if (remain_zero) begin
            do_err   = 1'b1;
            err_code = dtlv_pkg::ERR_INCOMPLETE;
          end else begin
            len_acc_d  = '0;
            len_left_d = n[3:0];
            phase_d    = dtlv_pkg::PH_LONG;
          end
        end
        dtlv_pkg::PH_LONG: begin
          len_acc_d  = len_acc_next;
          len_left_d = len_left_next;
          if (len_left_next == 4'd0) begin
            do_fin  = 1'b1;
            fin_len = len_acc_next;
          end else if (remain_zero) begin
            do_err   = 1'b1;
            err_code = dtlv_pkg::ERR_INCOMPLETE;
          end
        end
        default: begin
          phase_d = dtlv_pkg::PH_IDENT;
        end
      endcase

      // length must fit in what is left of the buffer
      if (do_fin && (fin_len > remain64)) begin
        do_fin   = 1'b0;
        do_err   = 1'b1;
        err_code = dtlv_pkg::ERR_LENGTH;
      end

      if (do_err) begin
        res_valid_o      = 1'b1;
        res_o.error_code = err_code;
      end else if (do_fin) begin
        res_valid_o       = 1'b1;
        res_o.error_code  = dtlv_pkg::ERR_OK;
        res_o.tag_number  = (base == dtlv_pkg::HIGH_TAG_MARK) ? tag_acc_q : 63'(base);
        res_o.tag_class   = id_q[7:6];
        res_o.constructed = id_q[5];
        res_o.univ_code   = (id_q[7:6] == 2'd0) ? dtlv_pkg::univ_type(base) : 5'd0;
        res_o.content_len = fin_len;
        res_o.hdr_len     = hbc_inc;
      end

      if (do_err || do_fin) begin
        phase_d = dtlv_pkg::PH_IDENT;
        hbc_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dtlv_pkg::PH_IDENT;
      tag_cnt_q  <= '0;
      len_left_q <= '0;
      hbc_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      tag_cnt_q  <= tag_cnt_d;
      len_left_q <= len_left_d;
      hbc_q      <= hbc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    tag_acc_q <= tag_acc_d;
    len_acc_q <= len_acc_d;
  end

endmodule

>>> rtl/core/dtlv_out_stage.sv
module dtlv_out_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  dtlv_pkg::result_t                 res_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [dtlv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  logic              valid_q, valid_d;
  dtlv_pkg::result_t res_q;

  assign valid_d = load_i || (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q.hdr_len, res_q.content_len,
                            res_q.univ_code, res_q.constructed, res_q.tag_class,
                            res_q.tag_number, res_q.error_code};

endmodule

>>> rtl/core/der_tlv_header_parser_unit.sv
// DER TLV header parser.
// Slave channel: one header byte per item, tdata = {bytes_after, data_byte}, where
// bytes_after is the number of buffer bytes following this byte.
// Master channel: one item per finished or failed header (none for bytes in between).
// An accepted byte waits in the input register, is decoded against the
// running header state, and any result is loaded into the output register:
// m_axis_tvalid_o rises once the last header byte has passed the input register.
// One byte per cycle is taken while no output item is held; the tag and length
// shift-accumulate and the length-against-buffer compare lie between the registers.
// A held output item stalls the decoder only when another byte is waiting, and the
// input register then holds its byte and drops s_axis_tready_o.
// Reset clears both valid flags and returns the decoder to waiting for an
// identifier byte; after any result the next byte is taken as a new identifier.
module der_tlv_header_parser_unit #(
  parameter int unsigned COUNT_BITS       = dtlv_pkg::COUNT_BITS_DEF,
  parameter int unsigned MAX_LENGTH_BYTES = dtlv_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // data_byte[7:0], bytes_after[39:8]
  input  logic [dtlv_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // error_code[1:0], tag_number[64:2], tag_class[66:65], constructed[67],
  // univ_code[72:68], content_len[136:73], hdr_len[141:137], zero[143:142]
  output logic [dtlv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

`include "der_tlv_header_parser_unit_macros.svh"

  logic              in_valid;
  dtlv_pkg::item_t   in_item;
  logic              advance;
  logic              res_valid;
  dtlv_pkg::result_t res;

  logic                             out_ok;
  logic                             out_held;
  logic [dtlv_pkg::OUT_TDATA_W-1:2] out_rest;
  logic [4:0]                       out_univ;
  logic [1:0]                       out_cls;
  logic [4:0]                       out_hdr_len;

  assign advance = in_valid && (!m_axis_tvalid_o || m_axis_tready_i);

  dtlv_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .advance_i       (advance),
    .valid_o         (in_valid),
    .item_o          (in_item)
  );

  dtlv_decoder #(
    .COUNT_BITS       (COUNT_BITS),
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (in_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dtlv_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && res_valid),
    .res_i           (res),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  assign out_ok      = (m_axis_tdata_o[1:0] == dtlv_pkg::ERR_OK);
  assign out_held    = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_rest    = m_axis_tdata_o[dtlv_pkg::OUT_TDATA_W-1:2];
  assign out_univ    = m_axis_tdata_o[72:68];
  assign out_cls     = m_axis_tdata_o[66:65];
  assign out_hdr_len = m_axis_tdata_o[141:137];

  // failed headers carry nothing but the code
  `DTLV_ASSERT_IMP(a_err_fields_zero, clk_i, rst_ni, m_axis_tvalid_o && !out_ok, out_rest == '0)
  // a good header has at least identifier and length bytes
  `DTLV_ASSERT_IMP(a_hdr_len_min, clk_i, rst_ni, m_axis_tvalid_o && out_ok, out_hdr_len >= 5'd2)
  // type code only for universal class
  `DTLV_ASSERT_IMP(a_univ_class, clk_i, rst_ni, m_axis_tvalid_o && (out_univ != 0), out_cls == 0)
  // a result is loaded only when the decoder consumes a byte
  `DTLV_ASSERT_NXT(a_load_from_byte, clk_i, rst_ni, !in_valid && !out_held, !m_axis_tvalid_o)

endmodule

>>> sim/der_tlv_header_parser_unit_tb.sv
`timescale 1ns / 1ps

module der_tlv_header_parser_unit_tb;

  localparam int unsigned MAX_LEN     = dtlv_pkg::MAX_LENGTH_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_BYTES  = 1950;
  localparam int unsigned QUIET_FROM  = 1650;
  localparam int unsigned HOLD_CYCLES = 400;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                             s_axis_tvalid = 1'b0;
  logic [dtlv_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             s_axis_tready;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [dtlv_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  der_tlv_header_parser_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Header decoder state, mirrored
  dtlv_pkg::phase_e hp_phase    = dtlv_pkg::PH_IDENT;
  logic [7:0]       hp_ident    = '0;
  logic [62:0]      hp_tag      = '0;
  logic [3:0]       hp_tag_cnt  = '0;
  logic [63:0]      hp_len      = '0;
  logic [3:0]       hp_len_left = '0;
  logic [4:0]       hp_hdr_cnt  = '0;

  dtlv_pkg::result_t hdr_expected[$];

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit rx_hold_req = 1'b0;

  int n_fail = 0;
  int n_bytes = 0;
  int n_hdrs = 0;
  int n_err_hdrs = 0;
  int unsigned cyc = 0;

  typedef struct {
    logic [7:0]        d;
    logic [31:0]       ba;
    bit                typed;
    dtlv_pkg::result_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  logic [7:0]  hdr_bytes[$];
  logic [31:0] hdr_counts[$];

  // Decode one header byte; returns 1 when a header result is due.
  function automatic bit decode_hdr_byte(input logic [7:0] b, input logic [31:0] remain,
                                         output dtlv_pkg::result_t r);
    bit             done;
    dtlv_pkg::err_e ec;
    logic [63:0]    ln;
    done = 1'b0;
    ec   = dtlv_pkg::ERR_OK;
    ln   = '0;
    r    = '0;
    hp_hdr_cnt = hp_hdr_cnt + 5'd1;
    case (hp_phase)
      dtlv_pkg::PH_IDENT: begin
        hp_ident   = b;
        hp_tag     = '0;
        hp_tag_cnt = '0;
        if (remain == 0) begin
          done = 1'b1;
          ec   = dtlv_pkg::ERR_INCOMPLETE;
        end else begin
          hp_phase = (b[4:0] == dtlv_pkg::HIGH_TAG_MARK) ? dtlv_pkg::PH_TAG
                                                        : dtlv_pkg::PH_LEN;
        end
      end
      dtlv_pkg::PH_TAG: begin
        hp_tag     = {hp_tag[55:0], b[6:0]};
        hp_tag_cnt = hp_tag_cnt + 4'd1;
        if (hp_tag_cnt >= dtlv_pkg::TAG_BYTES_MAX) begin
          done = 1'b1;
          ec   = dtlv_pkg::ERR_TAG_OVF;
        end else if (remain == 0) begin
          done = 1'b1;
          ec   = dtlv_pkg::ERR_INCOMPLETE;
        end else if (!b[7]) begin
          hp_phase = dtlv_pkg::PH_LEN;
        end
      end
      dtlv_pkg::PH_LEN: begin
        if (!b[7]) begin
          done = 1'b1;
          ln   = 64'(b);
        end else if (b[6:0] > MAX_LEN) begin
          done = 1'b1;
          ec   = dtlv_pkg::ERR_LENGTH;
        end else if (b[6:0] == 0) begin
          done = 1'b1;
        end else if (remain == 0) begin
          done = 1'b1;
          ec   = dtlv_pkg::ERR_INCOMPLETE;
        end else begin
          hp_len      = '0;
          hp_len_left = b[3:0];
          hp_phase    = dtlv_pkg::PH_LONG;
        end
      end
      default: begin
        hp_len      = {hp_len[55:0], b};
        hp_len_left = hp_len_left - 4'd1;
        if (hp_len_left == 0) begin
          done = 1'b1;
          ln   = hp_len;
        end else if (remain == 0) begin
          done = 1'b1;
          ec   = dtlv_pkg::ERR_INCOMPLETE;
        end
      end
    endcase
    if (done && ec == dtlv_pkg::ERR_OK && ln > 64'(remain)) ec = dtlv_pkg::ERR_LENGTH;
    if (done) begin
      r.error_code = ec;
      if (ec == dtlv_pkg::ERR_OK) begin
        r.tag_number  = (hp_ident[4:0] == dtlv_pkg::HIGH_TAG_MARK) ? hp_tag
                                                                  : 63'(hp_ident[4:0]);
        r.tag_class   = hp_ident[7:6];
        r.constructed = hp_ident[5];
        r.content_len = ln;
        r.hdr_len     = hp_hdr_cnt;
        if (hp_ident[7:6] == 2'd0) begin
          case (hp_ident[4:0])
            5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h06: r.univ_code = hp_ident[4:0];
            5'h0C:   r.univ_code = 5'd7;
            5'h10:   r.univ_code = 5'd8;
            5'h11:   r.univ_code = 5'd9;
            5'h13:   r.univ_code = 5'd10;
            5'h14:   r.univ_code = 5'd11;
            5'h16:   r.univ_code = 5'd12;
            5'h17:   r.univ_code = 5'd13;
            5'h18:   r.univ_code = 5'd14;
            5'h1C:   r.univ_code = 5'd15;
            5'h1E:   r.univ_code = 5'd16;
            default: r.univ_code = 5'd0;
          endcase
        end
      end
      hp_phase    = dtlv_pkg::PH_IDENT;
      hp_ident    = '0;
      hp_tag      = '0;
      hp_tag_cnt  = '0;
      hp_len      = '0;
      hp_len_left = '0;
      hp_hdr_cnt  = '0;
    end
    return done;
  endfunction

  function automatic dtlv_pkg::result_t mk_hdr(input dtlv_pkg::err_e ec,
                                               input logic [62:0] tag,
                                               input logic [1:0] cls, input logic cons,
                                               input logic [4:0] ut, input logic [63:0] vl,
                                               input logic [4:0] hl);
    dtlv_pkg::result_t r;
    r.error_code  = ec;
    r.tag_number  = tag;
    r.tag_class   = cls;
    r.constructed = cons;
    r.univ_code   = ut;
    r.content_len = vl;
    r.hdr_len     = hl;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] d, input logic [31:0] ba, input bit typed,
                         input dtlv_pkg::result_t res);
    dir_row_t row;
    row.d     = d;
    row.ba    = ba;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Offer one byte, wait for it to be taken, then maybe idle.
  task automatic send_byte(input logic [7:0] d, input logic [31:0] ba, input bit typed,
                           input dtlv_pkg::result_t res);
    dtlv_pkg::result_t pred;
    bit                got;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ba, d};
    do @(posedge clk_i); while (!s_axis_tready);
    got = decode_hdr_byte(d, ba, pred);
    if (typed) hdr_expected.push_back(res);
    else if (got) hdr_expected.push_back(pred);
    n_bytes++;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Mostly well-formed header with random content; some truncated or broken.
  task automatic build_header();
    logic [7:0]  ident;
    logic [7:0]  lb;
    logic [63:0] vlen;
    logic [63:0] room;
    int          ntag;
    int          nlen;
    int          form;
    int          hl;
    int          cut;
    int          i;
    hdr_bytes.delete();
    hdr_counts.delete();
    ident = 8'($urandom);
    if ($urandom_range(0, 1) == 0) ident[7:6] = 2'd0;
    if ($urandom_range(0, 3) == 0) ident[4:0] = dtlv_pkg::HIGH_TAG_MARK;
    hdr_bytes.push_back(ident);
    ntag = 0;
    vlen = '0;
    if (ident[4:0] == dtlv_pkg::HIGH_TAG_MARK) begin
      ntag = ($urandom_range(0, 9) == 0) ? 10 : $urandom_range(1, 9);
      for (i = 0; i < ntag; i++) begin
        lb = 8'($urandom);
        lb[7] = (i < ntag - 1) ? 1'b1 : ((ntag == 10) ? 1'($urandom) : 1'b0);
        hdr_bytes.push_back(lb);
      end
    end
    if (ntag < 10) begin
      form = $urandom_range(0, 9);
      if (form < 4) begin
        vlen = 64'($urandom_range(0, 127));
        hdr_bytes.push_back(8'(vlen));
      end else if (form == 4) begin
        hdr_bytes.push_back(8'h80);
      end else if (form < 9) begin
        nlen = $urandom_range(1, MAX_LEN);
        vlen = 64'($urandom) >> $urandom_range(0, 31);
        if (nlen > 4 && $urandom_range(0, 4) == 0) vlen[63:32] = $urandom;
        if (nlen < 8) vlen = vlen & ((64'd1 << (8 * nlen)) - 64'd1);
        hdr_bytes.push_back(8'h80 | 8'(nlen));
        for (i = nlen - 1; i >= 0; i--) hdr_bytes.push_back(8'(vlen >> (8 * i)));
      end else begin
        // length count beyond the limit
        hdr_bytes.push_back(8'h80 | 8'($urandom_range(MAX_LEN + 1, 127)));
      end
    end
    hl = hdr_bytes.size();
    if (vlen != 0 && $urandom_range(0, 9) == 0) room = vlen - 64'd1;
    else if ($urandom_range(0, 4) == 0) room = vlen + 64'($urandom);
    else room = vlen + 64'($urandom_range(0, 3));
    if (room > 64'hFFFF_FFFF - 64'(hl)) room = 64'hFFFF_FFFF - 64'(hl);
    cut = hl - 1;
    if ($urandom_range(0, 11) == 0) cut = $urandom_range(0, hl - 1);
    for (i = 0; i <= cut; i++) begin
      if (cut < hl - 1) hdr_counts.push_back(32'(cut - i));
      else hdr_counts.push_back(32'(room + 64'(hl - 1 - i)));
    end
    while (hdr_bytes.size() > cut + 1) void'(hdr_bytes.pop_back());
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      n_fail++;
    end
  endtask

  task automatic check_out_item();
    dtlv_pkg::result_t                want;
    logic [dtlv_pkg::OUT_TDATA_W-1:0] t;
    t = m_axis_tdata;
    if (hdr_expected.size() == 0) begin
      $error("header result item with none pending: 0x%0h", t);
      n_fail++;
    end else begin
      want = hdr_expected.pop_front();
      n_hdrs++;
      if (want.error_code != dtlv_pkg::ERR_OK) n_err_hdrs++;
      cmp_field("error_code",  64'(want.error_code),  64'(t[1:0]));
      cmp_field("tag_number",  64'(want.tag_number),  64'(t[64:2]));
      cmp_field("tag_class",   64'(want.tag_class),   64'(t[66:65]));
      cmp_field("constructed", 64'(want.constructed), 64'(t[67]));
      cmp_field("univ_code",   64'(want.univ_code),   64'(t[72:68]));
      cmp_field("content_len", want.content_len,      t[136:73]);
      cmp_field("hdr_len",     64'(want.hdr_len),     64'(t[141:137]));
    end
  endtask

  // Result side: check, then pick next tready
  initial begin
    int rx_stall;
    rx_stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_out_item();
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_req) begin
        // long hold-off so the block fills up and stalls its input
        rx_hold_req = 1'b0;
        rx_stall = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 14) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $error("cycle limit reached, %0d header results still pending", hdr_expected.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    dtlv_pkg::result_t none;
    logic [31:0]       ba;
    int                next_switch;
    int                i;
    none = '0;

    // after reset: INTEGER, short length 1
    add_row(8'h02, 32'd3, 1'b0, none);
    add_row(8'h01, 32'd2, 1'b1,
            mk_hdr(dtlv_pkg::ERR_OK, 63'd2, 2'd0, 1'b0, 5'd2, 64'd1, 5'd2));
    // identifier with nothing after it
    add_row(8'h30, 32'd0, 1'b1,
            mk_hdr(dtlv_pkg::ERR_INCOMPLETE, '0, '0, 1'b0, '0, '0, '0));
    // nine length bytes
    add_row(8'h04, 32'd10, 1'b0, none);
    add_row(8'h89, 32'd9, 1'b1,
            mk_hdr(dtlv_pkg::ERR_LENGTH, '0, '0, 1'b0, '0, '0, '0));
    // two-byte high tag, private constructed
    add_row(8'hFF, 32'd100, 1'b0, none);
    add_row(8'h81, 32'd99, 1'b0, none);
    add_row(8'h00, 32'd98, 1'b0, none);
    add_row(8'h10, 32'd97, 1'b0, none);
    // eight length bytes, largest count
    add_row(8'h04, 32'hFFFF_FFFF, 1'b0, none);
    add_row(8'h88, 32'hFFFF_FFFF, 1'b0, none);
    for (i = 0; i < 4; i++) add_row(8'h00, 32'hFFFF_FFFF, 1'b0, none);
    for (i = 0; i < 3; i++) add_row(8'hFF, 32'hFFFF_FFFF, 1'b0, none);
    add_row(8'hFF, 32'hFFFF_FFFF, 1'b1,
            mk_hdr(dtlv_pkg::ERR_OK, 63'd4, 2'd0, 1'b0, 5'd4, 64'hFFFF_FFFF, 5'd10));
    // tenth tag byte overflows
    add_row(8'h1F, 32'd50, 1'b0, none);
    for (i = 0; i < 9; i++) add_row(8'hFF, 32'(49 - i), 1'b0, none);
    add_row(8'h7F, 32'd40, 1'b1,
            mk_hdr(dtlv_pkg::ERR_TAG_OVF, '0, '0, 1'b0, '0, '0, '0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) send_byte(dir_rows[k].d, dir_rows[k].ba, dir_rows[k].typed,
                                    dir_rows[k].res);

    rx_hold_req = 1'b1;
    next_switch = n_bytes + 150;
    while (n_bytes < RAND_BYTES) begin
      if (n_bytes >= QUIET_FROM) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else if (n_bytes >= next_switch) begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
        next_switch += 150;
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       ba = '0;
          1:       ba = 32'($urandom_range(0, 40));
          default: ba = $urandom;
        endcase
        send_byte(8'($urandom), ba, 1'b0, none);
      end else begin
        build_header();
        foreach (hdr_bytes[k]) send_byte(hdr_bytes[k], hdr_counts[k], 1'b0, none);
      end
    end
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;

    while (hdr_expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (hdr_expected.size() != 0) begin
      $error("%0d header results never arrived", hdr_expected.size());
      n_fail++;
    end

    $display("Sent %0d header bytes (directed and random, with stalls on both sides).",
             n_bytes);
    $display("Checked %0d header results, %0d of them error results.", n_hdrs, n_err_hdrs);
    if (n_fail == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
